@@ rtl/slcsr_pkg.sv @@
// ----------------------------------------------------------------------------
// slcsr_pkg
// Shared types and constants of the lower-to-upper CSR converter.
// ----------------------------------------------------------------------------
package slcsr_pkg;

  localparam int MAX_ROWS          = 1024;
  localparam int MAX_LOWER_ENTRIES = 8192;
  localparam int OUT_DEPTH         = MAX_ROWS + MAX_LOWER_ENTRIES;

  localparam int IDX_W  = 14;
  localparam int COL_W  = 10;
  localparam int VAL_W  = 64;
  localparam int ROWS_W = 11;

  // Item kinds carried in the mode field.
  localparam logic [1:0] MODE_DIAG       = 2'd0;
  localparam logic [1:0] MODE_LOWER      = 2'd1;
  localparam logic [1:0] MODE_READ_PTR   = 2'd2;
  localparam logic [1:0] MODE_READ_ENTRY = 2'd3;

  // Configuration register indexes.
  localparam logic REG_ROW_COUNT  = 1'b0;
  localparam logic REG_INDEX_BASE = 1'b1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IDX_W-1:0] row_index;
    logic [COL_W-1:0] column_index;
    logic [VAL_W-1:0] entry_value;
    logic             load_last;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_index;
    logic [VAL_W-1:0] out_value;
    logic             error;
  } out_t;

endpackage

@@ rtl/slcsr_ram.sv @@
// ----------------------------------------------------------------------------
// slcsr_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module slcsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/sparse_lower_to_upper_csr.sv @@
// ----------------------------------------------------------------------------
// sparse_lower_to_upper_csr
// Symmetric sparse matrix loader and converter to upper-triangle CSR.
// ----------------------------------------------------------------------------
// Load beats (diagonal values and strictly lower entries) give no result
// unless they carry load_last. A read beat (row pointer or output entry)
// passes through the registered read of a memory and the S_READ state, and
// then its result sits in the output register. A beat with load_last starts
// the conversion, which walks the memories one access at a time, skipping
// held entries on rows no longer in use (one pass to set the column counts,
// one to count, one to form the row pointers and place the diagonals, one
// to scatter the entries). Its result carries the entry total plus the
// index base and the error flag.
// Input stalls while a conversion or a read is in flight, and while a result
// waits if the new beat would make another one.
module sparse_lower_to_upper_csr (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [10:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  slcsr_pkg::in_t      in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output slcsr_pkg::out_t     out_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_INIT  = 4'd2;
  localparam logic [3:0] S_CNT_A = 4'd3;
  localparam logic [3:0] S_CNT_B = 4'd4;
  localparam logic [3:0] S_CNT_C = 4'd5;
  localparam logic [3:0] S_PRE_A = 4'd6;
  localparam logic [3:0] S_PRE_B = 4'd7;
  localparam logic [3:0] S_SCT_A = 4'd8;
  localparam logic [3:0] S_SCT_B = 4'd9;
  localparam logic [3:0] S_SCT_C = 4'd10;
  localparam logic [3:0] S_DONE  = 4'd11;

  localparam int LD_W  = 2 * slcsr_pkg::COL_W + slcsr_pkg::VAL_W;
  localparam int OE_W  = slcsr_pkg::COL_W + slcsr_pkg::VAL_W;
  localparam int RA_W  = $clog2(slcsr_pkg::MAX_ROWS);
  localparam int LA_W  = $clog2(slcsr_pkg::MAX_LOWER_ENTRIES);
  localparam int OA_W  = $clog2(slcsr_pkg::OUT_DEPTH);

  logic [3:0]  state;
  logic [13:0] idx;
  logic [13:0] acc;
  logic [13:0] ld_count;
  logic        load_fault;
  logic        conv_bad;
  logic [10:0] conv_rows;
  logic [13:0] total;
  logic [10:0] row_count;
  logic        index_base;
  logic [1:0]  rd_mode;
  logic [13:0] rd_row;

  logic [10:0] n;
  logic        accept;
  logic        is_load;
  logic        diag_ok;
  logic        lower_ok;

  // Memory ports.
  logic            cnt_we;
  logic [RA_W-1:0] cnt_waddr, cnt_raddr;
  logic [13:0]     cnt_wdata, cnt_rdata;
  logic [63:0]     diag_rdata;
  logic [LD_W-1:0] ld_rdata;
  logic            out_we;
  logic [OA_W-1:0] out_waddr;
  logic [OE_W-1:0] out_wdata, out_rdata;
  logic            rp_we;
  logic [13:0]     rp_rdata;

  logic [9:0]  ld_row, ld_col;
  logic [63:0] ld_val;
  logic        ld_skip;

  // Read result, formed in S_READ.
  logic        rd_err;
  logic [13:0] rd_index;
  logic [63:0] rd_value;

  assign n = (row_count > 11'(slcsr_pkg::MAX_ROWS)) ? 11'(slcsr_pkg::MAX_ROWS) : row_count;

  assign is_load = (in_data.mode == slcsr_pkg::MODE_DIAG) ||
                   (in_data.mode == slcsr_pkg::MODE_LOWER);

  // Loads without last make no result, so they pass a waiting result by.
  assign in_stall = !((state == S_IDLE) &&
                      (!out_valid || (is_load && !in_data.load_last)));
  assign accept = in_valid && !in_stall;

  assign diag_ok  = in_data.row_index < {3'b0, n};
  assign lower_ok = (in_data.row_index < {3'b0, n}) &&
                    ({4'b0, in_data.column_index} < in_data.row_index) &&
                    (ld_count < 14'(slcsr_pkg::MAX_LOWER_ENTRIES));

  assign ld_row  = ld_rdata[LD_W-1 -: 10];
  assign ld_col  = ld_rdata[LD_W-11 -: 10];
  assign ld_val  = ld_rdata[63:0];
  assign ld_skip = {1'b0, ld_row} >= n;

  // Diagonal values, indexed by row.
  slcsr_ram #(.WIDTH(64), .DEPTH(slcsr_pkg::MAX_ROWS)) u_diag (
    .clk   (clk),
    .we    (accept && (in_data.mode == slcsr_pkg::MODE_DIAG) && diag_ok),
    .waddr (in_data.row_index[RA_W-1:0]),
    .wdata (in_data.entry_value),
    .raddr (idx[RA_W-1:0]),
    .rdata (diag_rdata)
  );

  // Held lower entries in arrival order: row, column, value.
  slcsr_ram #(.WIDTH(LD_W), .DEPTH(slcsr_pkg::MAX_LOWER_ENTRIES)) u_loaded (
    .clk   (clk),
    .we    (accept && (in_data.mode == slcsr_pkg::MODE_LOWER) && lower_ok),
    .waddr (ld_count[LA_W-1:0]),
    .wdata ({in_data.row_index[9:0], in_data.column_index, in_data.entry_value}),
    .raddr (idx[LA_W-1:0]),
    .rdata (ld_rdata)
  );

  // Column counts during counting, then next free slot per output row.
  slcsr_ram #(.WIDTH(14), .DEPTH(slcsr_pkg::MAX_ROWS)) u_count (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Output entries: column index and value.
  slcsr_ram #(.WIDTH(OE_W), .DEPTH(slcsr_pkg::OUT_DEPTH)) u_out (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_waddr),
    .wdata (out_wdata),
    .raddr (in_data.row_index[OA_W-1:0]),
    .rdata (out_rdata)
  );

  // Row pointers of rows below the converted row count; the last pointer
  // is the entry total and is kept in a register.
  slcsr_ram #(.WIDTH(14), .DEPTH(slcsr_pkg::MAX_ROWS)) u_rowptr (
    .clk   (clk),
    .we    (rp_we),
    .waddr (idx[RA_W-1:0]),
    .wdata (acc),
    .raddr (in_data.row_index[RA_W-1:0]),
    .rdata (rp_rdata)
  );

  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = ld_col;
    cnt_wdata = cnt_rdata + 14'd1;
    cnt_raddr = (state == S_PRE_A) ? idx[RA_W-1:0] : ld_col;
    out_we    = 1'b0;
    out_waddr = cnt_rdata;
    out_wdata = {ld_row, ld_val};
    rp_we     = 1'b0;
    case (state)
      S_INIT: begin
        cnt_we    = idx < {3'b0, n};
        cnt_waddr = idx[RA_W-1:0];
        cnt_wdata = 14'd1;
      end
      S_CNT_C: begin
        cnt_we = 1'b1;
      end
      S_PRE_B: begin
        // The row's diagonal goes first, at the row's pointer.
        cnt_we    = 1'b1;
        cnt_waddr = idx[RA_W-1:0];
        cnt_wdata = acc + 14'd1;
        out_we    = 1'b1;
        out_waddr = acc;
        out_wdata = {idx[9:0], diag_rdata};
        rp_we     = 1'b1;
      end
      S_SCT_C: begin
        cnt_we = 1'b1;
        out_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rd_err   = 1'b0;
    rd_index = '0;
    rd_value = '0;
    if (rd_mode == slcsr_pkg::MODE_READ_PTR) begin
      if (rd_row > {3'b0, conv_rows}) begin
        rd_err = 1'b1;
      end else if (rd_row == {3'b0, conv_rows}) begin
        rd_index = total + {13'b0, index_base};
      end else begin
        rd_index = rp_rdata + {13'b0, index_base};
      end
    end else begin
      if (rd_row >= total) begin
        rd_err = 1'b1;
      end else begin
        rd_index = {4'b0, out_rdata[OE_W-1 -: 10]} + {13'b0, index_base};
        rd_value = out_rdata[63:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= 11'd1;
      index_base <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        slcsr_pkg::REG_ROW_COUNT:  row_count  <= cfg_data;
        slcsr_pkg::REG_INDEX_BASE: index_base <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= '0;
      acc        <= '0;
      ld_count   <= '0;
      load_fault <= 1'b0;
      conv_bad   <= 1'b0;
      conv_rows  <= '0;
      total      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            rd_mode <= in_data.mode;
            rd_row  <= in_data.row_index;
            if (in_data.mode == slcsr_pkg::MODE_DIAG) begin
              if (!diag_ok) begin
                load_fault <= 1'b1;
              end
            end else if (in_data.mode == slcsr_pkg::MODE_LOWER) begin
              if (lower_ok) begin
                ld_count <= ld_count + 14'd1;
              end else begin
                load_fault <= 1'b1;
              end
            end
            if (!is_load) begin
              state <= S_READ;
            end else if (in_data.load_last) begin
              idx   <= '0;
              state <= S_INIT;
            end
          end
        end
        S_READ: begin
          out_valid          <= 1'b1;
          out_data.out_index <= rd_index;
          out_data.out_value <= rd_value;
          out_data.error     <= rd_err;
          state              <= S_IDLE;
        end
        S_INIT: begin
          if (idx < {3'b0, n}) begin
            idx <= idx + 14'd1;
          end else begin
            idx   <= '0;
            state <= S_CNT_A;
          end
        end
        S_CNT_A: begin
          if (idx < ld_count) begin
            state <= S_CNT_B;
          end else begin
            idx   <= '0;
            acc   <= '0;
            state <= S_PRE_A;
          end
        end
        S_CNT_B: begin
          // An entry whose row fell out of range since loading is skipped.
          if (ld_skip) begin
            conv_bad <= 1'b1;
            idx      <= idx + 14'd1;
            state    <= S_CNT_A;
          end else begin
            state <= S_CNT_C;
          end
        end
        S_CNT_C: begin
          idx   <= idx + 14'd1;
          state <= S_CNT_A;
        end
        S_PRE_A: begin
          if (idx < {3'b0, n}) begin
            state <= S_PRE_B;
          end else begin
            idx   <= '0;
            state <= S_SCT_A;
          end
        end
        S_PRE_B: begin
          acc   <= acc + cnt_rdata;
          idx   <= idx + 14'd1;
          state <= S_PRE_A;
        end
        S_SCT_A: begin
          state <= (idx < ld_count) ? S_SCT_B : S_DONE;
        end
        S_SCT_B: begin
          if (ld_skip) begin
            idx   <= idx + 14'd1;
            state <= S_SCT_A;
          end else begin
            state <= S_SCT_C;
          end
        end
        S_SCT_C: begin
          idx   <= idx + 14'd1;
          state <= S_SCT_A;
        end
        S_DONE: begin
          conv_rows          <= n;
          total              <= acc;
          out_valid          <= 1'b1;
          out_data.out_index <= acc + {13'b0, index_base};
          out_data.out_value <= '0;
          out_data.error     <= conv_bad || load_fault;
          ld_count           <= '0;
          load_fault         <= 1'b0;
          conv_bad           <= 1'b0;
          state              <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/slcsr_checker.sv @@
// ----------------------------------------------------------------------------
// slcsr_checker
// Port-level checks of the lower-to-upper CSR converter.
// ----------------------------------------------------------------------------
module slcsr_checker (
  input logic            clk,
  input logic            rst,
  input logic            cfg_write,
  input logic            cfg_index,
  input logic [10:0]     cfg_data,
  input logic            in_valid,
  input logic            in_stall,
  input slcsr_pkg::in_t  in_data,
  input logic            out_valid,
  input logic            out_stall,
  input slcsr_pkg::out_t out_data
);

  // A result that waits is not lost.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its beat.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // A read beat is answered after its memory read and the S_READ state.
  a_read_answer: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.mode[1] |=> ##1 out_valid)
    else $error("read beat not answered");

  // A read beat is never taken while a result still waits.
  a_read_waits: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && in_data.mode[1] |-> in_stall)
    else $error("read taken over a waiting result");

  // Reset leaves no result behind.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sparse_lower_to_upper_csr slcsr_checker u_slcsr_checker (.*);

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench for the symmetric lower-to-upper CSR converter. Load, conversion
// and read beats are driven with random bursts and gaps on the input side and
// a changing stall pattern on the output side. Every accepted beat runs
// through a predictor in this file, and every result beat is checked field by
// field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT = 2000000;

  logic            clk;
  logic            rst;
  logic            cfg_write;
  logic            cfg_index;
  logic [10:0]     cfg_data;
  logic            in_valid;
  logic            in_stall;
  slcsr_pkg::in_t  in_data;
  logic            out_valid;
  logic            out_stall;
  slcsr_pkg::out_t out_data;

  sparse_lower_to_upper_csr i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Clock with a period of two time units.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // Predictor state. It mirrors the register file and the memories of the
  // converter: diagonals, held lower entries, and the CSR result arrays.
  // --------------------------------------------------------------------------
  logic [10:0]                 row_count_reg;
  logic                        index_base_reg;
  int                          col_count  [slcsr_pkg::MAX_ROWS];
  logic [slcsr_pkg::VAL_W-1:0] diag_val   [slcsr_pkg::MAX_ROWS];
  bit                          diag_known [slcsr_pkg::MAX_ROWS];
  int                          held_row   [slcsr_pkg::MAX_LOWER_ENTRIES];
  int                          held_col   [slcsr_pkg::MAX_LOWER_ENTRIES];
  logic [slcsr_pkg::VAL_W-1:0] held_val   [slcsr_pkg::MAX_LOWER_ENTRIES];
  int                          held_count;
  int                          csr_col    [slcsr_pkg::OUT_DEPTH];
  logic [slcsr_pkg::VAL_W-1:0] csr_val    [slcsr_pkg::OUT_DEPTH];
  int                          row_ptr    [slcsr_pkg::MAX_ROWS+1];
  int                          conv_rows;
  bit                          load_fault;

  slcsr_pkg::out_t expected_results [$];
  int   fail_count;
  int   cycle_count;
  int   burst_left;
  int   hold_cycles;
  int   stall_kind;
  int   stall_phase;

  // Rows actually in use; register values above the memory depth saturate.
  function automatic int rows_in_use();
    return (row_count_reg > slcsr_pkg::MAX_ROWS) ? slcsr_pkg::MAX_ROWS
                                                 : int'(row_count_reg);
  endfunction

  // Builds the upper-triangle CSR arrays from the held entries. Returns 1 if
  // a held entry lies on a row that is no longer in use.
  function automatic bit build_csr();
    int n;
    int a;
    bit bad;
    n = rows_in_use();
    bad = 1'b0;
    for (int i = 0; i < n; i++) col_count[i] = 1;
    for (int j = 0; j < held_count; j++) begin
      if (held_row[j] >= n) bad = 1'b1;
      else col_count[held_col[j]]++;
    end
    row_ptr[0] = 0;
    for (int i = 0; i < n; i++) row_ptr[i+1] = row_ptr[i] + col_count[i];
    // The diagonal opens each row, then transposed entries in arrival order.
    for (int i = 0; i < n; i++) begin
      a = row_ptr[i];
      csr_col[a] = i;
      csr_val[a] = diag_val[i];
      col_count[i] = a + 1;
    end
    for (int j = 0; j < held_count; j++) begin
      if (held_row[j] < n) begin
        a = col_count[held_col[j]];
        csr_col[a] = held_row[j];
        csr_val[a] = held_val[j];
        col_count[held_col[j]] = a + 1;
      end
    end
    conv_rows = n;
    return bad;
  endfunction

  // Works out what one accepted beat does and queues its result, if any.
  function automatic void csr_predict(slcsr_pkg::in_t b);
    slcsr_pkg::out_t r;
    int   n;
    int   row;
    int   total;
    bit   bad;
    r   = '0;
    n   = rows_in_use();
    row = int'(b.row_index);
    if (b.mode == slcsr_pkg::MODE_READ_PTR) begin
      if (row > conv_rows) r.error = 1'b1;
      else r.out_index = slcsr_pkg::IDX_W'(row_ptr[row] + index_base_reg);
      expected_results = {expected_results, r};
    end else if (b.mode == slcsr_pkg::MODE_READ_ENTRY) begin
      total = row_ptr[conv_rows];
      if (row >= total || row >= slcsr_pkg::OUT_DEPTH) begin
        r.error = 1'b1;
      end else begin
        r.out_index = slcsr_pkg::IDX_W'(csr_col[row] + index_base_reg);
        r.out_value = csr_val[row];
      end
      expected_results = {expected_results, r};
    end else begin
      if (b.mode == slcsr_pkg::MODE_DIAG) begin
        if (row < n) begin
          diag_val[row]   = b.entry_value;
          diag_known[row] = 1'b1;
        end else begin
          load_fault = 1'b1;
        end
      end else if (row >= n || int'(b.column_index) >= row ||
                   held_count >= slcsr_pkg::MAX_LOWER_ENTRIES) begin
        load_fault = 1'b1;
      end else begin
        held_row[held_count] = row;
        held_col[held_count] = int'(b.column_index);
        held_val[held_count] = b.entry_value;
        held_count++;
      end
      if (b.load_last) begin
        bad = build_csr();
        r.out_index = slcsr_pkg::IDX_W'(row_ptr[conv_rows] + index_base_reg);
        r.error     = bad | load_fault;
        held_count  = 0;
        load_fault  = 1'b0;
        expected_results = {expected_results, r};
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checker: a result beat is taken first, then the input beat of the same
  // edge is predicted. A result can never belong to an input of the same edge
  // because the output is registered.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    slcsr_pkg::out_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time, out_data);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.out_index !== want.out_index) begin
            $display("%0t: out_index expected %0d actual %0d",
                     $time, want.out_index, out_data.out_index);
            fail_count++;
          end
          if (out_data.out_value !== want.out_value) begin
            $display("%0t: out_value expected %h actual %h",
                     $time, want.out_value, out_data.out_value);
            fail_count++;
          end
          if (out_data.error !== want.error) begin
            $display("%0t: error expected %b actual %b",
                     $time, want.error, out_data.error);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) csr_predict(in_data);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver stall. A long hold-off, when requested, overrides the pattern;
  // otherwise the pattern switches at random between no stall, light, heavy
  // and a regular toggle.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0) stall_kind <= $urandom_range(0, 3);
      case (stall_kind)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= stall_phase[1];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All of them start and end at a falling edge.
  // --------------------------------------------------------------------------

  // Offers one beat and returns once it is accepted. Valid stays high across
  // a burst; between bursts the sender usually pauses for a random gap.
  task automatic send_beat(logic [1:0] mode, int row, int col,
                           logic [slcsr_pkg::VAL_W-1:0] value, bit last);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_data.mode         = mode;
    in_data.row_index    = slcsr_pkg::IDX_W'(row);
    in_data.column_index = slcsr_pkg::COL_W'(col);
    in_data.entry_value  = value;
    in_data.load_last    = last;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    burst_left--;
  endtask

  function automatic logic [slcsr_pkg::VAL_W-1:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  // Waits until every expected result has come, then lets the block settle.
  task automatic wait_idle();
    in_valid = 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = 11'(value);
    if (idx == slcsr_pkg::REG_ROW_COUNT) row_count_reg = 11'(value);
    else index_base_reg = value[0];
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_config(int rows, bit base);
    wait_idle();
    write_reg(slcsr_pkg::REG_ROW_COUNT, rows);
    write_reg(slcsr_pkg::REG_INDEX_BASE, base);
  endtask

  // Loads every diagonal in use that has never been written, so that the
  // conversion never picks up an unwritten diagonal.
  task automatic fill_diagonals();
    for (int i = 0; i < rows_in_use(); i++)
      if (!diag_known[i])
        send_beat(slcsr_pkg::MODE_DIAG, i, $urandom, rand_value(), 1'b0);
  endtask

  // One random read beat: mostly in range, sometimes just past the end, and
  // now and then a fully random position.
  task automatic random_read();
    int total;
    int pos;
    bit ptr;
    total = row_ptr[conv_rows];
    ptr = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 7))
      0: pos = $urandom_range(0, 16383);
      1: pos = ptr ? conv_rows + $urandom_range(1, 3) : total + $urandom_range(0, 2);
      default: pos = ptr ? $urandom_range(0, conv_rows)
                         : (total > 0 ? $urandom_range(0, total - 1) : 0);
    endcase
    send_beat(ptr ? slcsr_pkg::MODE_READ_PTR : slcsr_pkg::MODE_READ_ENTRY, pos,
              $urandom, rand_value(), 1'($urandom_range(0, 1)));
  endtask

  // One random load beat: mostly a well-formed lower entry, with diagonals,
  // out-of-range rows and columns not below their row mixed in.
  task automatic random_load(bit last);
    int n;
    int r;
    n = rows_in_use();
    case ($urandom_range(0, 9))
      0: send_beat(slcsr_pkg::MODE_DIAG, (n > 0) ? $urandom_range(0, n - 1) : 0,
                   $urandom, rand_value(), last);
      1: send_beat(2'($urandom_range(0, 1)), $urandom_range(n, 16383), $urandom,
                   rand_value(), last);
      2: begin
        r = (n > 0) ? $urandom_range(0, n - 1) : 0;
        send_beat(slcsr_pkg::MODE_LOWER, r, $urandom_range(r, 1023), rand_value(),
                  last);
      end
      default: begin
        if (n < 2) begin
          send_beat(slcsr_pkg::MODE_LOWER, 0, $urandom, rand_value(), last);
        end else begin
          r = $urandom_range(1, n - 1);
          send_beat(slcsr_pkg::MODE_LOWER, r, $urandom_range(0, r - 1), rand_value(),
                    last);
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // A small hand-built matrix with both index bases, the value extremes,
  // the dropped loads of bad rows and columns, and reads in and out of range.
  task automatic test_small_matrix();
    set_config(4, 1'b1);
    send_beat(slcsr_pkg::MODE_DIAG, 0, 0, '0, 1'b0);
    send_beat(slcsr_pkg::MODE_DIAG, 1, 1023, '1, 1'b0);
    send_beat(slcsr_pkg::MODE_DIAG, 2, 0, 64'h0123_4567_89ab_cdef, 1'b0);
    send_beat(slcsr_pkg::MODE_DIAG, 3, 0, 64'h8000_0000_0000_0001, 1'b0);
    send_beat(slcsr_pkg::MODE_DIAG, 4, 0, rand_value(), 1'b0);
    send_beat(slcsr_pkg::MODE_LOWER, 3, 0, '1, 1'b0);
    send_beat(slcsr_pkg::MODE_LOWER, 3, 2, 64'h5555_aaaa_5555_aaaa, 1'b0);
    send_beat(slcsr_pkg::MODE_LOWER, 1, 0, '0, 1'b0);
    send_beat(slcsr_pkg::MODE_LOWER, 2, 2, rand_value(), 1'b0);
    send_beat(slcsr_pkg::MODE_LOWER, 16383, 1023, rand_value(), 1'b0);
    send_beat(slcsr_pkg::MODE_LOWER, 2, 1, rand_value(), 1'b0);
    send_beat(slcsr_pkg::MODE_LOWER, 3, 1, rand_value(), 1'b1);
    for (int i = 0; i <= 5; i++) send_beat(slcsr_pkg::MODE_READ_PTR, i, 0, '0, i[0]);
    for (int i = 0; i <= 10; i++)
      send_beat(slcsr_pkg::MODE_READ_ENTRY, i, 1023, '1, i[0]);
    send_beat(slcsr_pkg::MODE_READ_ENTRY, 16383, 0, '0, 1'b0);
    send_beat(slcsr_pkg::MODE_READ_PTR, 16383, 0, '0, 1'b1);
    // A clean conversion with base zero: a diagonal beat carries the last flag.
    set_config(4, 1'b0);
    send_beat(slcsr_pkg::MODE_LOWER, 1, 0, rand_value(), 1'b0);
    send_beat(slcsr_pkg::MODE_DIAG, 2, 0, rand_value(), 1'b1);
    for (int i = 0; i < 6; i++) send_beat(slcsr_pkg::MODE_READ_ENTRY, i, 0, '0, 1'b0);
  endtask

  // Entries held while the row count is cut back: those on rows no longer in
  // use are skipped, and the conversion flags an error.
  task automatic test_shrunk_rows();
    set_config(8, 1'b0);
    fill_diagonals();
    for (int i = 0; i < 12; i++) begin
      send_beat(slcsr_pkg::MODE_LOWER, $urandom_range(1, 7), 0, rand_value(), 1'b0);
    end
    set_config(4, 1'b1);
    send_beat(slcsr_pkg::MODE_DIAG, 0, 0, rand_value(), 1'b1);
    for (int i = 0; i < 8; i++) random_read();
  endtask

  // Row count zero drops every load; the conversion yields no entries.
  task automatic test_zero_rows();
    set_config(0, 1'b1);
    send_beat(slcsr_pkg::MODE_DIAG, 0, 0, rand_value(), 1'b0);
    send_beat(slcsr_pkg::MODE_LOWER, 1, 0, rand_value(), 1'b1);
    send_beat(slcsr_pkg::MODE_READ_PTR, 0, 0, '0, 1'b0);
    send_beat(slcsr_pkg::MODE_READ_PTR, 1, 0, '0, 1'b0);
    send_beat(slcsr_pkg::MODE_READ_ENTRY, 0, 0, '0, 1'b0);
    set_config(0, 1'b0);
    send_beat(slcsr_pkg::MODE_DIAG, 5, 0, rand_value(), 1'b1);
  endtask

  // The receiver holds off for a long stretch while reads keep coming, so
  // the result register fills and the input stalls.
  task automatic test_backpressure();
    wait_idle();
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) random_read();
  endtask

  // Random phases: a register setting, diagonals where needed, a run of
  // loads ending in a conversion, then reads of the result. Most phases use
  // few rows; a few use the full depth, the first through a saturating value.
  task automatic test_random(int beats);
    int done;
    int phase;
    int rows;
    done = 0;
    phase = 0;
    while (done < beats) begin
      case (phase % 9)
        1: rows = (phase < 9) ? 2047 : $urandom_range(1, 60);
        2: rows = slcsr_pkg::MAX_ROWS;
        4: rows = $urandom_range(0, 2);
        default: rows = $urandom_range(2, 40);
      endcase
      set_config(rows, 1'($urandom_range(0, 1)));
      fill_diagonals();
      done += rows_in_use();
      for (int k = $urandom_range(0, 40); k > 0; k--) begin
        random_load(1'b0);
        done++;
      end
      random_load(1'b1);
      for (int k = $urandom_range(4, 30); k > 0; k--) begin
        random_read();
        done++;
      end
      done++;
      phase++;
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = slcsr_pkg::REG_ROW_COUNT;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    hold_cycles = 0;
    stall_kind = 0;
    stall_phase = 0;
    burst_left = 0;
    fail_count = 0;
    cycle_count = 0;
    row_count_reg = 11'd1;
    index_base_reg = 1'b0;
    held_count = 0;
    conv_rows = 0;
    load_fault = 1'b0;
    foreach (diag_known[i]) diag_known[i] = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_small_matrix();
    test_zero_rows();
    test_shrunk_rows();
    test_backpressure();
    test_random(1000);

    wait_idle();
    repeat (50) @(negedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/slcsr_pkg.sv
rtl/slcsr_ram.sv
rtl/sparse_lower_to_upper_csr.sv
rtl/slcsr_checker.sv
sim/tb.sv
